// ===== rtl/spra_pkg.sv =====
`timescale 1ns / 1ps
package spra_pkg;

  localparam int MAX_ELEMENTS = 128;
  localparam int MAX_SHARERS  = 256;
  localparam int PAGE_BITS    = 12;
  localparam int IDX_W        = 7;
  localparam int LEN_W        = 8;
  localparam int REF_W        = 9;
  localparam int ADDR_W       = 32;
  localparam int BASE_W       = ADDR_W - PAGE_BITS;
  localparam int PAGES_W      = ADDR_W + 2 - PAGE_BITS;

  typedef enum logic [2:0] {
    STAT_NEW        = 3'd0,
    STAT_SHARED     = 3'd1,
    STAT_NOROOM     = 3'd2,
    STAT_REL_SHARED = 3'd3,
    STAT_REL_FREED  = 3'd4,
    STAT_BAD        = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SHARE_SCAN,
    S_FIT_SCAN,
    S_FIT_WR_REST,
    S_FIT_WR_BEST,
    S_REL_CHK,
    S_FWD_NEXT,
    S_FWD_CHK,
    S_BWD_NEXT,
    S_BWD_CHK,
    S_FINAL_WR,
    S_EMIT
  } state_t;

  // One slot descriptor as held in the slot memory
  typedef struct packed {
    logic              head;
    logic [LEN_W-1:0]  len;
    logic [REF_W-1:0]  refs;
    logic [BASE_W-1:0] base;
  } entry_t;

  // Decoded allocate request
  typedef struct packed {
    logic              zero;
    logic              too_big;
    logic [LEN_W-1:0]  need;
    logic [BASE_W-1:0] base;
  } req_t;

endpackage

// ===== rtl/spra_ram.sv =====
`timescale 1ns / 1ps
module spra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/spra_page.sv =====
`timescale 1ns / 1ps
module spra_page (
  input  logic [spra_pkg::ADDR_W-1:0] addr,
  input  logic [spra_pkg::ADDR_W-1:0] bytes,
  input  logic [spra_pkg::LEN_W-1:0]  total,
  output spra_pkg::req_t              req
);

  logic [spra_pkg::ADDR_W+1:0]  span;
  logic [spra_pkg::PAGES_W-1:0] pages;

  // Round the byte span out to whole pages
  always_comb begin
    span  = (spra_pkg::ADDR_W+2)'(addr[spra_pkg::PAGE_BITS-1:0])
          + (spra_pkg::ADDR_W+2)'(bytes)
          + (spra_pkg::ADDR_W+2)'((1 << spra_pkg::PAGE_BITS) - 1);
    pages = span[spra_pkg::ADDR_W+1:spra_pkg::PAGE_BITS];
    req.zero    = (bytes == '0);
    req.too_big = (pages > spra_pkg::PAGES_W'(total));
    req.need    = pages[spra_pkg::LEN_W-1:0];
    req.base    = addr[spra_pkg::ADDR_W-1:spra_pkg::PAGE_BITS];
  end

endmodule

// ===== rtl/shared_page_run_allocator.sv =====
`timescale 1ns / 1ps
// Page run allocator over a 128-slot descriptor memory. An allocate walks the
// slot memory for a sharing match and, if none is found, again for a best
// fit, one slot per cycle through the single read port. A release that leaves
// the run shared only drops one reference; one that frees the run absorbs the
// free runs that follow it, then walks back slot by slot to each previous run
// head and absorbs those that are free, before the merged run is written. A
// zero-length, oversized or out-of-range request goes straight to its result.
// After reset and after each write of total_elements a clearing pass over all
// 128 slots rebuilds the pool, with busy high. Each request that is not cut
// short by a write of total_elements yields exactly one result, shown for one
// cycle with out_valid; it cannot be held off.
module shared_page_run_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [31:0] in_buffer_address,
  input  logic [31:0] in_buffer_bytes,
  input  logic [6:0]  in_run_handle,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [6:0]  out_run_start,
  output logic [7:0]  out_run_length,
  output logic [8:0]  out_ref_count,
  output logic [7:0]  out_free_slots,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int IW = spra_pkg::IDX_W;
  localparam int LW = spra_pkg::LEN_W;
  localparam int RW = spra_pkg::REF_W;
  localparam int BW = spra_pkg::BASE_W;

  spra_pkg::state_t  state_r, state_nxt;
  logic [LW-1:0]     total_r, total_nxt;
  logic [LW-1:0]     free_r, free_nxt;
  logic [LW-1:0]     idx_r, idx_nxt;
  logic              pv_r, pv_nxt;
  logic [IW-1:0]     pidx_r, pidx_nxt;
  logic [LW-1:0]     need_r, need_nxt;
  logic [BW-1:0]     base_r, base_nxt;
  logic              found_r, found_nxt;
  logic [IW-1:0]     best_r, best_nxt;
  logic [LW-1:0]     bestlen_r, bestlen_nxt;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [LW-1:0]     curlen_r, curlen_nxt;
  logic [BW-1:0]     curbase_r, curbase_nxt;
  logic [IW-1:0]     j_r, j_nxt;
  logic [2:0]        rs_status_r, rs_status_nxt;
  logic [IW-1:0]     rs_start_r, rs_start_nxt;
  logic [LW-1:0]     rs_len_r, rs_len_nxt;
  logic [RW-1:0]     rs_refs_r, rs_refs_nxt;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  spra_pkg::entry_t  ram_wdata, e;
  spra_pkg::req_t    req;
  logic [LW-1:0]     cfg_total;
  logic [LW:0]       fwd_nxt, fsum;
  logic              accept;
  logic              share_hit, fit_hit;

  spra_ram #(.WIDTH($bits(spra_pkg::entry_t)), .DEPTH(spra_pkg::MAX_ELEMENTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (e)
  );

  spra_page u_page (
    .addr  (in_buffer_address),
    .bytes (in_buffer_bytes),
    .total (total_r),
    .req   (req)
  );

  // Clamp the configured slot count into range
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_total = LW'(1);
    end else if (cfg_wdata > LW'(spra_pkg::MAX_ELEMENTS)) begin
      cfg_total = LW'(spra_pkg::MAX_ELEMENTS);
    end else begin
      cfg_total = cfg_wdata;
    end
  end

  assign accept    = start && (state_r == spra_pkg::S_IDLE);
  assign fwd_nxt   = (LW+1)'(cur_r) + (LW+1)'(curlen_r);
  assign fsum      = (LW+1)'(free_r) + (LW+1)'(e.len);
  assign share_hit = pv_r && e.head && (e.refs != '0) && (e.base == base_r)
                     && (e.len == need_r);
  assign fit_hit   = pv_r && e.head && (e.refs == '0) && (e.len >= need_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spra_pkg::S_CLEAR: begin
        if (idx_r == LW'(spra_pkg::MAX_ELEMENTS - 1)) state_nxt = spra_pkg::S_IDLE;
      end
      spra_pkg::S_IDLE: begin
        if (accept) begin
          if (in_op) begin
            state_nxt = (LW'(in_run_handle) >= total_r) ? spra_pkg::S_EMIT
                                                         : spra_pkg::S_REL_CHK;
          end else if (req.zero || req.too_big) begin
            state_nxt = spra_pkg::S_EMIT;
          end else begin
            state_nxt = spra_pkg::S_SHARE_SCAN;
          end
        end
      end
      spra_pkg::S_SHARE_SCAN: begin
        if (share_hit) state_nxt = spra_pkg::S_EMIT;
        else if (idx_r == total_r && !pv_r) state_nxt = spra_pkg::S_FIT_SCAN;
      end
      spra_pkg::S_FIT_SCAN: begin
        if (idx_r == total_r && !pv_r) begin
          state_nxt = found_r ? spra_pkg::S_FIT_WR_REST : spra_pkg::S_EMIT;
        end
      end
      spra_pkg::S_FIT_WR_REST: state_nxt = spra_pkg::S_FIT_WR_BEST;
      spra_pkg::S_FIT_WR_BEST: state_nxt = spra_pkg::S_EMIT;
      spra_pkg::S_REL_CHK: begin
        if (!e.head || e.refs == '0 || e.refs != RW'(1)) state_nxt = spra_pkg::S_EMIT;
        else state_nxt = spra_pkg::S_FWD_NEXT;
      end
      spra_pkg::S_FWD_NEXT: begin
        if (curlen_r == '0 || fwd_nxt >= (LW+1)'(total_r)) state_nxt = spra_pkg::S_BWD_NEXT;
        else state_nxt = spra_pkg::S_FWD_CHK;
      end
      spra_pkg::S_FWD_CHK: begin
        state_nxt = (e.head && e.refs == '0) ? spra_pkg::S_FWD_NEXT : spra_pkg::S_BWD_NEXT;
      end
      spra_pkg::S_BWD_NEXT: begin
        state_nxt = (cur_r == '0) ? spra_pkg::S_FINAL_WR : spra_pkg::S_BWD_CHK;
      end
      spra_pkg::S_BWD_CHK: begin
        if (e.head) begin
          state_nxt = (e.refs != '0) ? spra_pkg::S_FINAL_WR : spra_pkg::S_BWD_NEXT;
        end else if (j_r == '0) begin
          state_nxt = spra_pkg::S_FINAL_WR;
        end
      end
      spra_pkg::S_FINAL_WR: state_nxt = spra_pkg::S_EMIT;
      spra_pkg::S_EMIT:     state_nxt = spra_pkg::S_IDLE;
      default:              state_nxt = spra_pkg::S_IDLE;
    endcase
    if (cfg_we) state_nxt = spra_pkg::S_CLEAR;
  end

  // Handshake outputs
  always_comb begin
    busy      = (state_r != spra_pkg::S_IDLE);
    out_valid = (state_r == spra_pkg::S_EMIT);
  end

  // Memory control and datapath
  always_comb begin
    total_nxt     = total_r;
    free_nxt      = free_r;
    idx_nxt       = idx_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    need_nxt      = need_r;
    base_nxt      = base_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    bestlen_nxt   = bestlen_r;
    cur_nxt       = cur_r;
    curlen_nxt    = curlen_r;
    curbase_nxt   = curbase_r;
    j_nxt         = j_r;
    rs_status_nxt = rs_status_r;
    rs_start_nxt  = rs_start_r;
    rs_len_nxt    = rs_len_r;
    rs_refs_nxt   = rs_refs_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[IW-1:0];
    ram_wdata     = '0;
    ram_raddr     = idx_r[IW-1:0];

    case (state_r)
      // Sweep the pool: slot zero holds one free run
      spra_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[IW-1:0];
        if (idx_r == '0) begin
          ram_wdata.head = 1'b1;
          ram_wdata.len  = total_r;
        end
        idx_nxt = idx_r + LW'(1);
      end
      spra_pkg::S_IDLE: begin
        ram_raddr = in_run_handle;
        if (accept) begin
          need_nxt      = req.need;
          base_nxt      = req.base;
          idx_nxt       = '0;
          found_nxt     = 1'b0;
          cur_nxt       = in_run_handle;
          rs_status_nxt = spra_pkg::STAT_BAD;
          rs_start_nxt  = '0;
          rs_len_nxt    = '0;
          rs_refs_nxt   = '0;
          if (!in_op && !req.zero && req.too_big) rs_status_nxt = spra_pkg::STAT_NOROOM;
        end
      end
      // Look for a live run with the same base and length
      spra_pkg::S_SHARE_SCAN: begin
        if (idx_r < total_r) begin
          ram_raddr = idx_r[IW-1:0];
          idx_nxt   = idx_r + LW'(1);
          pv_nxt    = 1'b1;
          pidx_nxt  = idx_r[IW-1:0];
        end
        if (share_hit) begin
          if (e.refs >= RW'(spra_pkg::MAX_SHARERS)) begin
            rs_status_nxt = spra_pkg::STAT_BAD;
          end else begin
            ram_we         = 1'b1;
            ram_waddr      = pidx_r;
            ram_wdata      = e;
            ram_wdata.refs = e.refs + RW'(1);
            rs_status_nxt  = spra_pkg::STAT_SHARED;
            rs_start_nxt   = pidx_r;
            rs_len_nxt     = e.len;
            rs_refs_nxt    = e.refs + RW'(1);
          end
        end else if (idx_r == total_r && !pv_r) begin
          idx_nxt = '0;
        end
      end
      // Keep the smallest free run that fits, first one on ties
      spra_pkg::S_FIT_SCAN: begin
        if (idx_r < total_r) begin
          ram_raddr = idx_r[IW-1:0];
          idx_nxt   = idx_r + LW'(1);
          pv_nxt    = 1'b1;
          pidx_nxt  = idx_r[IW-1:0];
        end
        if (fit_hit && (!found_r || e.len < bestlen_r)) begin
          found_nxt   = 1'b1;
          best_nxt    = pidx_r;
          bestlen_nxt = e.len;
        end
        if (idx_r == total_r && !pv_r && !found_r) rs_status_nxt = spra_pkg::STAT_NOROOM;
      end
      // Split off the remainder as a free run
      spra_pkg::S_FIT_WR_REST: begin
        if (need_r < bestlen_r && (LW+1)'(best_r) + (LW+1)'(need_r)
            < (LW+1)'(spra_pkg::MAX_ELEMENTS)) begin
          ram_we         = 1'b1;
          ram_waddr      = best_r + IW'(need_r);
          ram_wdata.head = 1'b1;
          ram_wdata.len  = bestlen_r - need_r;
        end
      end
      spra_pkg::S_FIT_WR_BEST: begin
        ram_we         = 1'b1;
        ram_waddr      = best_r;
        ram_wdata.head = 1'b1;
        ram_wdata.len  = need_r;
        ram_wdata.refs = RW'(1);
        ram_wdata.base = base_r;
        free_nxt       = (free_r >= need_r) ? free_r - need_r : '0;
        rs_status_nxt  = spra_pkg::STAT_NEW;
        rs_start_nxt   = best_r;
        rs_len_nxt     = need_r;
        rs_refs_nxt    = RW'(1);
      end
      // Drop one reference; free the run at zero
      spra_pkg::S_REL_CHK: begin
        if (e.head && e.refs != '0) begin
          rs_start_nxt = cur_r;
          rs_len_nxt   = e.len;
          rs_refs_nxt  = e.refs - RW'(1);
          if (e.refs != RW'(1)) begin
            ram_we         = 1'b1;
            ram_waddr      = cur_r;
            ram_wdata      = e;
            ram_wdata.refs = e.refs - RW'(1);
            rs_status_nxt  = spra_pkg::STAT_REL_SHARED;
          end else begin
            rs_status_nxt = spra_pkg::STAT_REL_FREED;
            free_nxt      = (fsum > (LW+1)'(total_r)) ? total_r : fsum[LW-1:0];
            curlen_nxt    = e.len;
            curbase_nxt   = e.base;
          end
        end
      end
      // Absorb free runs that follow
      spra_pkg::S_FWD_NEXT: begin
        ram_raddr = fwd_nxt[IW-1:0];
      end
      spra_pkg::S_FWD_CHK: begin
        if (e.head && e.refs == '0) begin
          ram_we     = 1'b1;
          ram_waddr  = fwd_nxt[IW-1:0];
          curlen_nxt = curlen_r + e.len;
        end
      end
      // Walk back to the previous head
      spra_pkg::S_BWD_NEXT: begin
        j_nxt     = cur_r - IW'(1);
        ram_raddr = cur_r - IW'(1);
      end
      spra_pkg::S_BWD_CHK: begin
        if (e.head) begin
          if (e.refs == '0) begin
            ram_we      = 1'b1;
            ram_waddr   = cur_r;
            cur_nxt     = j_r;
            curlen_nxt  = curlen_r + e.len;
            curbase_nxt = e.base;
          end
        end else if (j_r != '0) begin
          j_nxt     = j_r - IW'(1);
          ram_raddr = j_r - IW'(1);
        end
      end
      spra_pkg::S_FINAL_WR: begin
        ram_we         = 1'b1;
        ram_waddr      = cur_r;
        ram_wdata.head = 1'b1;
        ram_wdata.len  = curlen_r;
        ram_wdata.base = curbase_r;
      end
      default: begin
      end
    endcase

    if (cfg_we) begin
      total_nxt = cfg_total;
      free_nxt  = cfg_total;
      idx_nxt   = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spra_pkg::S_CLEAR;
      total_r <= LW'(spra_pkg::MAX_ELEMENTS);
      free_r  <= LW'(spra_pkg::MAX_ELEMENTS);
      idx_r   <= '0;
      pv_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      free_r  <= free_nxt;
      idx_r   <= idx_nxt;
      pv_r    <= pv_nxt;
      found_r <= found_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pidx_r      <= pidx_nxt;
    need_r      <= need_nxt;
    base_r      <= base_nxt;
    best_r      <= best_nxt;
    bestlen_r   <= bestlen_nxt;
    cur_r       <= cur_nxt;
    curlen_r    <= curlen_nxt;
    curbase_r   <= curbase_nxt;
    j_r         <= j_nxt;
    rs_status_r <= rs_status_nxt;
    rs_start_r  <= rs_start_nxt;
    rs_len_r    <= rs_len_nxt;
    rs_refs_r   <= rs_refs_nxt;
  end

  assign out_status     = rs_status_r;
  assign out_run_start  = rs_start_r;
  assign out_run_length = rs_len_r;
  assign out_ref_count  = rs_refs_r;
  assign out_free_slots = free_r;

endmodule

// ===== rtl/spra_chk.sv =====
`timescale 1ns / 1ps
module spra_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [6:0]  out_run_start,
  input logic [7:0]  out_run_length,
  input logic [8:0]  out_ref_count,
  input logic [7:0]  out_free_slots
);

  // A taken request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept did not raise busy");

  // Result beats are single: never two in a row
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back to back result beats");

  a_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result beat while idle");

  // Failed requests carry empty run fields
  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == spra_pkg::STAT_NOROOM || out_status == spra_pkg::STAT_BAD)
    |-> out_run_start == '0 && out_run_length == '0 && out_ref_count == '0)
    else $error("failed request with nonzero run fields");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_free_slots <= 8'(spra_pkg::MAX_ELEMENTS))
    else $error("free count out of range");

endmodule

bind shared_page_run_allocator spra_chk u_spra_chk (.*);
